>>> rtl/second_order_difference_controller_assert.svh
// assertion macros used by the controller checker
`ifndef SECOND_ORDER_DIFFERENCE_CONTROLLER_ASSERT_SVH
`define SECOND_ORDER_DIFFERENCE_CONTROLLER_ASSERT_SVH

// same-cycle implication, checked on every rising edge outside reset
`define SODC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define SODC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/sodc_pkg.sv
// shared types, constants and codes of the second-order difference controller
`default_nettype none

package sodc_pkg;

  localparam int COEF_W     = 24;
  localparam int SAMP_W     = 16;
  localparam int ERR_W      = 17;
  localparam int CMD_W      = 32;
  localparam int PROD_W     = 56;
  localparam int ACC_W      = 60;
  localparam int REM_W      = 25;
  localparam int CNT_W      = 5;
  localparam int MUL_STEPS  = 5;
  localparam int DIV_CYCLES = 30;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [CMD_W-1:0] CMD_MAX = 32'h7fff_ffff;
  localparam logic [CMD_W-1:0] CMD_MIN = 32'h8000_0000;

  localparam logic signed [COEF_W-1:0] RST_ERR_NOW   = 24'sd1956250;
  localparam logic signed [COEF_W-1:0] RST_ERR_PREV  = -24'sd3901030;
  localparam logic signed [COEF_W-1:0] RST_ERR_PREV2 = 24'sd1944781;
  localparam logic signed [COEF_W-1:0] RST_OUT_NORM  = 24'sd4096;
  localparam logic signed [COEF_W-1:0] RST_OUT_PREV  = -24'sd7803;
  localparam logic signed [COEF_W-1:0] RST_OUT_PREV2 = 24'sd3706;

  typedef enum logic [2:0] {
    REG_ERR_NOW   = 3'd0,
    REG_ERR_PREV  = 3'd1,
    REG_ERR_PREV2 = 3'd2,
    REG_OUT_NORM  = 3'd3,
    REG_OUT_PREV  = 3'd4,
    REG_OUT_PREV2 = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEL_ERR0 = 3'd0,
    SEL_ERR1 = 3'd1,
    SEL_ERR2 = 3'd2,
    SEL_CMD1 = 3'd3,
    SEL_CMD2 = 3'd4
  } mul_sel_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] err_now;
    logic signed [COEF_W-1:0] err_prev;
    logic signed [COEF_W-1:0] err_prev2;
    logic signed [COEF_W-1:0] out_norm;
    logic signed [COEF_W-1:0] out_prev;
    logic signed [COEF_W-1:0] out_prev2;
  } coef_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] setpoint;
    logic signed [SAMP_W-1:0] measured;
  } sample_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] command;
    logic                    saturated;
    logic                    zero_divisor;
  } result_t;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_en;
    logic     div_init;
    logic     div_step;
    logic     finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/sodc_regs.sv
// coefficient register file behind the apb-style configuration port
`default_nettype none

module sodc_regs
  import sodc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output coef_t                  coef
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.err_now   <= RST_ERR_NOW;
      coef.err_prev  <= RST_ERR_PREV;
      coef.err_prev2 <= RST_ERR_PREV2;
      coef.out_norm  <= RST_OUT_NORM;
      coef.out_prev  <= RST_OUT_PREV;
      coef.out_prev2 <= RST_OUT_PREV2;
    end else if (wr) begin
      case (idx)
        REG_ERR_NOW:   coef.err_now   <= pwdata[COEF_W-1:0];
        REG_ERR_PREV:  coef.err_prev  <= pwdata[COEF_W-1:0];
        REG_ERR_PREV2: coef.err_prev2 <= pwdata[COEF_W-1:0];
        REG_OUT_NORM:  coef.out_norm  <= pwdata[COEF_W-1:0];
        REG_OUT_PREV:  coef.out_prev  <= pwdata[COEF_W-1:0];
        REG_OUT_PREV2: coef.out_prev2 <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ERR_NOW:   prdata = DATA_W'(coef.err_now);
      REG_ERR_PREV:  prdata = DATA_W'(coef.err_prev);
      REG_ERR_PREV2: prdata = DATA_W'(coef.err_prev2);
      REG_OUT_NORM:  prdata = DATA_W'(coef.out_norm);
      REG_OUT_PREV:  prdata = DATA_W'(coef.out_prev);
      REG_OUT_PREV2: prdata = DATA_W'(coef.out_prev2);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sodc_ctrl.sv
// sequencing state machine: multiply steps, divider cycles, result hand-off
`default_nettype none

module sodc_ctrl
  import sodc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     sample_valid,
  output logic          sample_stall,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_LAST  = 6'b000100,
    ST_DINIT = 6'b001000,
    ST_DIV   = 6'b010000,
    ST_FIN   = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  assign sample_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    cmd          = '0;
    cmd.mul_sel  = SEL_ERR0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mul_sel_t'(cnt[2:0]);
        cmd.acc_en  = (cnt != '0);
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_LAST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_LAST: begin
        cmd.acc_en = 1'b1;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_CYCLES - 1)) begin
          cnt_next   = '0;
          state_next = ST_FIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/sodc_dp.sv
// datapath: history, shared multiplier, accumulator, restoring divider, output register
`default_nettype none

module sodc_dp
  import sodc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  dp_cmd_t   cmd,
  input  coef_t     coef,
  input  sample_t   sample,
  output dp_stat_t  stat,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result
);

  // one restoring division step: shift in the next dividend bit, try subtract
  function automatic logic [REM_W+ACC_W-1:0] div_bit(
    input logic [REM_W-1:0]  r,
    input logic [ACC_W-1:0]  q,
    input logic [COEF_W-1:0] d
  );
    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] dd;
    rs = {r[REM_W-2:0], q[ACC_W-1]};
    dd = {1'b0, d};
    if (rs >= dd) begin
      return {rs - dd, q[ACC_W-2:0], 1'b1};
    end else begin
      return {rs, q[ACC_W-2:0], 1'b0};
    end
  endfunction

  function automatic logic signed [ERR_W-1:0] err_of(
    input logic signed [SAMP_W-1:0] r,
    input logic signed [SAMP_W-1:0] m
  );
    return $signed({r[SAMP_W-1], r}) - $signed({m[SAMP_W-1], m});
  endfunction

  // current sample and history
  logic signed [SAMP_W-1:0] r0, m0, r1, m1, r2, m2;
  logic signed [CMD_W-1:0]  u1, u2;

  // multiply-accumulate
  logic signed [ERR_W-1:0]  e0, e1, e2, esel;
  logic signed [COEF_W-1:0] mul_c;
  logic signed [CMD_W-1:0]  mul_x;
  logic signed [PROD_W-1:0] prod;
  logic                     prod_sub;
  logic signed [ACC_W-1:0]  acc;
  logic        [ACC_W-1:0]  pext;

  // divider
  logic [REM_W-1:0]          rem;
  logic [ACC_W-1:0]          quo;
  logic [COEF_W-1:0]         dmag;
  logic                      neg;
  logic [REM_W+ACC_W-1:0]    step_a, step_b;

  // final shaping
  logic                      zero_div, sat_hi, sat_lo;
  logic [CMD_W-1:0]          mag32;
  result_t                   res_next;

  assign e0 = err_of(r0, m0);
  assign e1 = err_of(r1, m1);
  assign e2 = err_of(r2, m2);

  always_comb begin
    esel  = e0;
    mul_c = coef.err_now;
    mul_x = '0;
    unique case (cmd.mul_sel)
      SEL_ERR0: begin
        mul_c = coef.err_now;
        esel  = e0;
      end
      SEL_ERR1: begin
        mul_c = coef.err_prev;
        esel  = e1;
      end
      SEL_ERR2: begin
        mul_c = coef.err_prev2;
        esel  = e2;
      end
      SEL_CMD1: mul_c = coef.out_prev;
      SEL_CMD2: mul_c = coef.out_prev2;
      default:  mul_c = coef.err_now;
    endcase
    if (cmd.mul_sel == SEL_CMD1) begin
      mul_x = u1;
    end else if (cmd.mul_sel == SEL_CMD2) begin
      mul_x = u2;
    end else begin
      mul_x = {{(CMD_W-ERR_W){esel[ERR_W-1]}}, esel};
    end
  end

  assign pext   = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign step_a = div_bit(rem, quo, dmag);
  assign step_b = div_bit(step_a[REM_W+ACC_W-1:ACC_W], step_a[ACC_W-1:0], dmag);

  always_comb begin
    zero_div = (coef.out_norm == '0);
    sat_hi   = !neg && (|quo[ACC_W-1:CMD_W-1]);
    sat_lo   = neg && ((|quo[ACC_W-1:CMD_W]) || (quo[CMD_W-1] && (|quo[CMD_W-2:0])));
    mag32    = quo[CMD_W-1:0];
    res_next = '0;
    if (zero_div) begin
      res_next.zero_divisor = 1'b1;
    end else if (sat_hi) begin
      res_next.command   = CMD_MAX;
      res_next.saturated = 1'b1;
    end else if (sat_lo) begin
      res_next.command   = CMD_MIN;
      res_next.saturated = 1'b1;
    end else begin
      res_next.command = neg ? -mag32 : mag32;
    end
  end

  assign stat.out_busy = result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0  <= sample.setpoint;
      m0  <= sample.measured;
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= prod_sub ? (acc - pext) : (acc + pext);
    end
    if (cmd.mul_en) begin
      prod     <= mul_c * mul_x;
      prod_sub <= (cmd.mul_sel == SEL_CMD1) || (cmd.mul_sel == SEL_CMD2);
    end
    if (cmd.div_init) begin
      neg  <= acc[ACC_W-1] ^ coef.out_norm[COEF_W-1];
      quo  <= acc[ACC_W-1] ? -acc : acc;
      rem  <= '0;
      dmag <= coef.out_norm[COEF_W-1] ? -coef.out_norm : coef.out_norm;
    end else if (cmd.div_step) begin
      rem <= step_b[REM_W+ACC_W-1:ACC_W];
      quo <= step_b[ACC_W-1:0];
    end
    if (cmd.finish) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1           <= '0;
      r2           <= '0;
      m1           <= '0;
      m2           <= '0;
      u1           <= '0;
      u2           <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        r2           <= r1;
        r1           <= r0;
        m2           <= m1;
        m1           <= m0;
        u2           <= u1;
        u1           <= res_next.command;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/second_order_difference_controller.sv
// top level of the second-order difference controller
// Second-order difference-equation controller. Each sample beat carries a
// setpoint and a measurement (signed Q3.12); each one produces exactly one
// result beat with u = (a*e0 + b*e1 + g*e2 - b1*u1 - g1*u2) / a1 as a signed
// Q19.12 command, truncated toward zero, clipped to 32 bits with the saturated
// flag, or forced to zero with the zero_divisor flag when a1 is zero. After
// acceptance an item passes through the multiply steps on the single shared
// 24x32 multiplier, a step to fold in the last product, a step to set up the
// divider, the restoring divider that retires two quotient bits a cycle over
// the 60-bit numerator, and a step to write the history and the output
// register; the next beat is taken back in the idle state. A held result
// does not block input: a new sample is taken while the previous result
// still sits in the output register; only the final write-back step waits
// for that register to drain. Coefficients sit behind an apb-style port at
// byte address 4*i in the order a, b, g, a1, b1, g1, 24-bit signed Q11.12;
// the user must write them only while the block is idle, which the block
// itself does not enforce.
`default_nettype none

module second_order_difference_controller
  import sodc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  // sample channel
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  sample_t                sample,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_stall,
  output result_t                result
);

  coef_t    coef;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // coefficient registers
  sodc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef    (coef)
  );

  // sequencer: owns the sample handshake, drives the datapath steps
  sodc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  // arithmetic, history and the output register
  sodc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .coef         (coef),
    .sample       (sample),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> rtl/sodc_checker.sv
// port-level checker for the second-order difference controller, with its bind
`default_nettype none

`include "second_order_difference_controller_assert.svh"

module sodc_checker
  import sodc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic sample_valid,
  input wire logic sample_stall,
  input wire logic result_valid,
  input wire logic result_stall,
  input result_t   result
);

  `SODC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                    result_valid && $stable(result), "stalled result beat changed")
  `SODC_ASSERT_NEXT(a_busy_after_take, sample_valid && !sample_stall, sample_stall,
                    "sample taken but block not busy")
  `SODC_ASSERT_NOW(a_zero_div_shape, result_valid && result.zero_divisor,
                   (result.command == '0) && !result.saturated,
                   "zero divisor with nonzero command")
  `SODC_ASSERT_NOW(a_sat_bound, result_valid && result.saturated,
                   (result.command == CMD_MAX) || (result.command == CMD_MIN),
                   "saturated command off bound")

endmodule

bind second_order_difference_controller sodc_checker u_checker (.*);

`default_nettype wire
